### rtl/core/cses_pkg.sv
// Shared types and constants for the chunked-body SSE event extractor.
// Used by every module of the block; no dependencies.
package cses_pkg;

	localparam int          MAX_HEX_DIGITS = 8;
	localparam int          OQ_DEPTH       = 4;
	localparam logic [15:0] CAP_RESET      = 16'd256;

	localparam logic [7:0]  CH_CR = 8'h0D;
	localparam logic [7:0]  CH_LF = 8'h0A;
	localparam logic [7:0]  CH_SP = 8'h20;

	localparam logic [31:0] EVENT_END_MARK = 32'h0D0A_0D0A;
	localparam logic [39:0] DATA_MARK      = 40'h64_6174_613A;

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_OK       = 3'd1,
		KIND_FORMAT   = 3'd2,
		KIND_OVERFLOW = 3'd3,
		KIND_FRAMING  = 3'd4,
		KIND_END      = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} res_t;

	// framing -> event side, per accepted byte
	typedef struct packed {
		logic pay;   // byte is payload of a chunk
		logic drop;  // discard the event being built
	} frm_ctl_t;

endpackage

### rtl/core/cses_frame.sv
// Chunk framing decoder: size line, payload count, trailer skip, resync.
// Depends on cses_pkg.
module cses_frame #(
	parameter int MaxHexDigits = cses_pkg::MAX_HEX_DIGITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        din,
	output cses_pkg::frm_ctl_t ctl,
	output cses_pkg::res_t    res,
	output logic              res_vld
);
	import cses_pkg::*;

	localparam int CntW = $clog2(MaxHexDigits + 1);

	typedef enum logic [2:0] {
		PH_SIZE, PH_SIZE_LF, PH_PAYLOAD, PH_TRAILER, PH_RESYNC, PH_ENDED
	} phase_t;

	phase_t            ph_q, ph_d;
	logic [31:0]       size_q, size_d;
	logic [CntW-1:0]   cnt_q, cnt_d;
	logic [31:0]       rem_q, rem_d;
	logic              trl_q, trl_d;
	logic              hex_ok;
	logic [3:0]        hex_val;
	logic              ferr;
	frm_ctl_t          ctl_v;
	logic              end_v;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (din >= 8'h30 && din <= 8'h39) begin
			hex_val = din[3:0];
		end else if ((din >= 8'h61 && din <= 8'h66) || (din >= 8'h41 && din <= 8'h46)) begin
			hex_val = din[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		ph_d   = ph_q;
		size_d = size_q;
		cnt_d  = cnt_q;
		rem_d  = rem_q;
		trl_d  = trl_q;
		ferr   = 1'b0;
		end_v  = 1'b0;
		ctl_v  = '0;
		case (ph_q)
			PH_SIZE: begin
				if (hex_ok) begin
					if (cnt_q >= CntW'(MaxHexDigits)) begin
						ferr = 1'b1;
					end else begin
						size_d = {size_q[27:0], hex_val};
						cnt_d  = cnt_q + CntW'(1);
					end
				end else if (din == CH_CR && cnt_q != '0) begin
					ph_d = PH_SIZE_LF;
				end else begin
					ferr = 1'b1;
				end
			end
			PH_SIZE_LF: begin
				if (din != CH_LF) begin
					ferr = 1'b1;
				end else if (size_q == '0) begin
					ctl_v.drop = 1'b1;
					end_v      = 1'b1;
					ph_d       = PH_ENDED;
				end else begin
					rem_d = size_q;
					ph_d  = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				ctl_v.pay = 1'b1;
				rem_d     = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					trl_d = 1'b0;
					ph_d  = PH_TRAILER;
				end
			end
			PH_TRAILER: begin
				trl_d = ~trl_q;
				if (trl_q) begin
					ph_d   = PH_SIZE;
					size_d = '0;
					cnt_d  = '0;
				end
			end
			PH_RESYNC: begin
				if (din == CH_LF) begin
					ph_d   = PH_SIZE;
					size_d = '0;
					cnt_d  = '0;
				end
			end
			PH_ENDED: begin
			end
			default: begin
				ph_d   = PH_SIZE;
				size_d = '0;
				cnt_d  = '0;
			end
		endcase
		if (ferr) begin
			ctl_v.drop = 1'b1;
			size_d     = '0;
			cnt_d      = '0;
			ph_d       = (din == CH_LF) ? PH_SIZE : PH_RESYNC;
		end
	end

	assign ctl      = acc ? ctl_v : '0;
	assign res_vld  = acc & (ferr | end_v);
	assign res.kind = end_v ? KIND_END : KIND_FRAMING;
	assign res.data = 8'h00;
	assign res.last = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_SIZE;
			size_q <= '0;
			cnt_q  <= '0;
			rem_q  <= '0;
			trl_q  <= 1'b0;
		end else if (acc) begin
			ph_q   <= ph_d;
			size_q <= size_d;
			cnt_q  <= cnt_d;
			rem_q  <= rem_d;
			trl_q  <= trl_d;
		end
	end

endmodule

### rtl/core/cses_sse.sv
// Event extractor on the decoded payload: "data:" search, content, status.
// Depends on cses_pkg.
module cses_sse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pay,
	input  logic           drop,
	input  logic [7:0]     din,
	input  logic [15:0]    cap,
	output cses_pkg::res_t res0,
	output logic           vld0,
	output cses_pkg::res_t res1,
	output logic           vld1
);
	import cses_pkg::*;

	typedef enum logic [1:0] {FD_SEARCH, FD_SKIP, FD_CONTENT, FD_CONTENT_CR} field_t;
	typedef enum logic [1:0] {FLT_NONE, FLT_FORMAT, FLT_OVERFLOW} fault_t;

	logic [39:0] rec_q, rec_d;
	field_t      fd_q, fd_d;
	logic [15:0] cnt_q, cnt_d;
	logic        line_q, line_d;
	fault_t      flt_q, flt_d;

	always_comb begin : step
		logic [39:0] rec_n;
		logic        want0, want1;
		logic [7:0]  byte0, byte1;
		fault_t      fend;

		rec_n  = {rec_q[31:0], din};
		rec_d  = rec_q;
		fd_d   = fd_q;
		cnt_d  = cnt_q;
		line_d = line_q;
		flt_d  = flt_q;
		want0  = 1'b0;
		want1  = 1'b0;
		byte0  = din;
		byte1  = din;
		fend   = flt_q;
		vld0   = 1'b0;
		vld1   = 1'b0;
		res0   = '{kind: KIND_DATA, data: din, last: 1'b0};
		res1   = '{kind: KIND_DATA, data: din, last: 1'b0};

		if (drop) begin
			rec_d  = '0;
			fd_d   = FD_SEARCH;
			cnt_d  = '0;
			line_d = 1'b0;
			flt_d  = FLT_NONE;
		end else if (pay) begin
			rec_d = rec_n;
			if (rec_n[31:0] == EVENT_END_MARK) begin
				if (flt_q == FLT_NONE && fd_q == FD_SKIP)
					fend = FLT_FORMAT;
				vld0 = 1'b1;
				case (fend)
					FLT_NONE:   res0.kind = KIND_OK;
					FLT_FORMAT: res0.kind = KIND_FORMAT;
					default:    res0.kind = KIND_OVERFLOW;
				endcase
				res0.data = 8'h00;
				res0.last = 1'b1;
				rec_d     = '0;
				fd_d      = FD_SEARCH;
				cnt_d     = '0;
				line_d    = 1'b0;
				flt_d     = FLT_NONE;
			end else begin
				case (fd_q)
					FD_SEARCH: begin
						if (rec_n == DATA_MARK)
							fd_d = FD_SKIP;
					end
					FD_SKIP: begin
						if (din != CH_SP && din != CH_CR && din != CH_LF) begin
							// every data line after the first of an event gets a newline first
							want0  = line_q;
							byte0  = CH_LF;
							want1  = 1'b1;
							line_d = 1'b1;
							fd_d   = FD_CONTENT;
						end
					end
					FD_CONTENT: begin
						if (din == CH_CR)
							fd_d = FD_CONTENT_CR;
						else
							want1 = 1'b1;
					end
					default: begin
						if (din == CH_LF) begin
							fd_d = FD_SEARCH;
						end else if (din == CH_CR) begin
							want0 = 1'b1;
							byte0 = CH_CR;
						end else begin
							want0 = 1'b1;
							byte0 = CH_CR;
							want1 = 1'b1;
							fd_d  = FD_CONTENT;
						end
					end
				endcase

				if (want0 && flt_d == FLT_NONE) begin
					if ({1'b0, cnt_d} + 17'd1 >= {1'b0, cap}) begin
						flt_d = FLT_OVERFLOW;
					end else begin
						vld0      = 1'b1;
						res0.data = byte0;
						cnt_d     = cnt_d + 16'd1;
					end
				end
				if (want1 && flt_d == FLT_NONE) begin
					if ({1'b0, cnt_d} + 17'd1 >= {1'b0, cap}) begin
						flt_d = FLT_OVERFLOW;
					end else begin
						vld1      = 1'b1;
						res1.data = byte1;
						cnt_d     = cnt_d + 16'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q  <= '0;
			fd_q   <= FD_SEARCH;
			cnt_q  <= '0;
			line_q <= 1'b0;
			flt_q  <= FLT_NONE;
		end else begin
			rec_q  <= rec_d;
			fd_q   <= fd_d;
			cnt_q  <= cnt_d;
			line_q <= line_d;
			flt_q  <= flt_d;
		end
	end

endmodule

### rtl/core/cses_outq.sv
// Result queue: takes up to two results per beat in order, hands out one.
// Depends on cses_pkg.
module cses_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push0,
	input  cses_pkg::res_t din0,
	input  logic           push1,
	input  cses_pkg::res_t din1,
	output logic           in_rdy,
	output logic           out_vld,
	input  logic           out_rdy,
	output cses_pkg::res_t dout
);
	import cses_pkg::*;

	localparam int PtrW = $clog2(OQ_DEPTH);
	localparam int CntW = $clog2(OQ_DEPTH + 1);

	res_t            ent_q [OQ_DEPTH];
	logic [PtrW-1:0] wr_q, rd_q, wr1;
	logic [CntW-1:0] cnt_q;
	logic            pop;

	assign pop     = out_vld & out_rdy;
	assign out_vld = (cnt_q != '0);
	assign in_rdy  = (cnt_q <= CntW'(OQ_DEPTH - 2));
	assign dout    = ent_q[rd_q];
	assign wr1     = push0 ? wr_q + PtrW'(1) : wr_q;

	always_ff @(posedge clk) begin
		if (push0)
			ent_q[wr_q] <= din0;
		if (push1)
			ent_q[wr1] <= din1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PtrW'(push0) + PtrW'(push1);
			rd_q  <= rd_q + PtrW'(pop);
			cnt_q <= cnt_q + CntW'(push0) + CntW'(push1) - CntW'(pop);
		end
	end

endmodule

### rtl/core/chunked_sse_event_extractor_core.sv
// Top level of the chunked-body SSE event extractor.
// Depends on cses_pkg, cses_frame, cses_sse, cses_outq.
//
// Usage:
//   s_* carries one byte of the chunked HTTP body per beat (s_tdata).
//   m_* carries result items: m_tuser is the kind (data byte, event ok,
//   format error, overflow, framing error, stream end), m_tdata the content
//   byte for data items (zero otherwise), m_tlast marks status items.
//   cfg_* writes the event capacity (reset 256); write it only while idle.
// Timing:
//   Each byte is decoded in the cycle it is accepted; its results are
//   registered into a four-entry result queue and leave it on m_* in order.
//   With m_tready high, one byte per cycle is taken while each byte
//   yields at most one result. A byte that yields two results (separator
//   plus content) pushes both into the queue, which hands them out one by
//   one; s_tready drops only when fewer than two queue entries are free.
// Reset clears all parsing state and empties the queue. A stalled m_tready
// holds the head item; input is taken until fewer than two entries are free.
// After the stream-end item, bytes are still taken but produce nothing.
module chunked_sse_event_extractor_core #(
	parameter int MAX_HEX_DIGITS = cses_pkg::MAX_HEX_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] raw_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_byte
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // event_capacity
);
	import cses_pkg::*;

	logic        acc;
	logic [15:0] cap_q;
	frm_ctl_t    ctl;
	res_t        frm_res, sse_res0, sse_res1, head;
	logic        frm_vld, sse_vld0, sse_vld1;

	assign acc       = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_q <= CAP_RESET;
		else if (cfg_valid)
			cap_q <= cfg_data;
	end

	cses_frame #(.MaxHexDigits(MAX_HEX_DIGITS)) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.din     (s_tdata),
		.ctl     (ctl),
		.res     (frm_res),
		.res_vld (frm_vld)
	);

	cses_sse u_sse (
		.clk    (clk),
		.arst_n (arst_n),
		.pay    (ctl.pay),
		.drop   (ctl.drop),
		.din    (s_tdata),
		.cap    (cap_q),
		.res0   (sse_res0),
		.vld0   (sse_vld0),
		.res1   (sse_res1),
		.vld1   (sse_vld1)
	);

	// framing results and event results never occur on the same byte
	cses_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push0   (frm_vld | sse_vld0),
		.din0    (frm_vld ? frm_res : sse_res0),
		.push1   (sse_vld1),
		.din1    (sse_res1),
		.in_rdy  (s_tready),
		.out_vld (m_tvalid),
		.out_rdy (m_tready),
		.dout    (head)
	);

	assign m_tuser = head.kind;
	assign m_tdata = head.data;
	assign m_tlast = head.last;

endmodule

### rtl/core/cses_chk.sv
// Port-level checks for the chunked-body SSE event extractor, bound to the top.
// Depends on cses_pkg and chunked_sse_event_extractor_core.
module cses_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic       m_tlast
);
	import cses_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result beat changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= KIND_END)
		else $error("undefined result kind");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != KIND_DATA))
			&& (m_tuser == KIND_DATA || m_tdata == 8'h00))
		else $error("tlast or data inconsistent with kind");

	a_end_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == KIND_END |=> !m_tvalid)
		else $error("result after stream end");

endmodule

bind chunked_sse_event_extractor_core cses_chk u_cses_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
